// File: hdl/ins_pkg.sv
`timescale 1ns / 1ps

package ins_pkg;

    localparam int COLS_W     = 6;
    localparam int ROWS_W     = 16;
    localparam int THR_W      = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COLS_W-1:0] COLS_RST = 6'd30;
    localparam logic [ROWS_W-1:0] ROWS_RST = 16'd20;
    localparam logic [THR_W-1:0]  THR_RST  = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS   = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_THRESH = 2'd2
    } cfg_idx_t;

    // result order within one input item
    typedef enum logic [1:0] {
        SLOT_MID   = 2'd0,
        SLOT_LEFT  = 2'd1,
        SLOT_FINAL = 2'd2
    } slot_t;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nb_valid_t;

endpackage

// File: hdl/ins_cell.sv
`timescale 1ns / 1ps

module ins_cell #(
    parameter int PIXEL_BITS = 4
) (
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic [PIXEL_BITS-1:0] pend_in,
    input  logic [PIXEL_BITS-1:0] smooth_in,
    output logic [PIXEL_BITS-1:0] pend,
    output logic [PIXEL_BITS-1:0] smooth
);

    logic [PIXEL_BITS-1:0] pend_reg;
    logic [PIXEL_BITS-1:0] smooth_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            pend_reg   <= pend_in;
            smooth_reg <= smooth_in;
        end
    end

    assign pend   = pend_reg;
    assign smooth = smooth_reg;

endmodule

// File: hdl/ins_smooth.sv
`timescale 1ns / 1ps

module ins_smooth #(
    parameter int PIXEL_BITS = 4
) (
    input  logic [PIXEL_BITS-1:0]      center,
    input  logic [PIXEL_BITS-1:0]      up,
    input  logic [PIXEL_BITS-1:0]      down,
    input  logic [PIXEL_BITS-1:0]      left,
    input  logic [PIXEL_BITS-1:0]      right,
    input  ins_pkg::nb_valid_t         valid,
    input  logic [ins_pkg::THR_W-1:0]  threshold,
    output logic [PIXEL_BITS-1:0]      result
);

    import ins_pkg::*;

    localparam int SUM_W  = PIXEL_BITS + 2;
    localparam int SHIFT  = SUM_W + 1;
    localparam int PROD_W = SUM_W + SHIFT;
    localparam int DIFF_W = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
    // ceil(2^SHIFT / 3): exact floor(x / 3) for every x below 2^SUM_W
    localparam logic [SHIFT-1:0] DIV3_MUL = SHIFT'(((64'd1 << SHIFT) + 64'd2) / 64'd3);

    logic [PIXEL_BITS-1:0] nb   [4];
    logic [PIXEL_BITS-1:0] diff [4];
    logic [3:0]            vb;
    logic [3:0]            close;
    logic [SUM_W-1:0]      sum;
    logic [2:0]            cnt;
    logic [PROD_W-1:0]     prod;
    logic [PIXEL_BITS-1:0] mean;

    always_comb
    begin
        nb[0] = up;
        nb[1] = down;
        nb[2] = left;
        nb[3] = right;
        vb    = {valid.right, valid.left, valid.down, valid.up};
        sum   = '0;
        for (int i = 0; i < 4; i++)
        begin
            diff[i]  = (center > nb[i]) ? (center - nb[i]) : (nb[i] - center);
            close[i] = vb[i] && (DIFF_W'(diff[i]) <= DIFF_W'(threshold));
            sum      = sum + (vb[i] ? SUM_W'(nb[i]) : '0);
        end
        cnt  = 3'($countones(vb));
        prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    end

    always_comb
    begin
        case (cnt)
            3'd1:    mean = sum[PIXEL_BITS-1:0];
            3'd2:    mean = sum[PIXEL_BITS:1];
            3'd3:    mean = prod[SHIFT +: PIXEL_BITS];
            3'd4:    mean = sum[PIXEL_BITS+1:2];
            default: mean = center;
        endcase
        result = ((close == 4'd0) && (cnt != 3'd0)) ? mean : center;
    end

endmodule

// File: hdl/impulse_noise_smoother_top.sv
`timescale 1ns / 1ps

// The result for row r-1, column c is queued when row r, column c is taken, then registered out.
// Throughput: one item per cycle along a row, held while an item's results are still queued
//   or the output stalls; the column ring then turns idle until its head is back at column 0;
//   last-row items after the first emit two results (three at the last column), one per cycle.
// Reset: position, ring head, left neighbors and handshakes clear, registers take their
//   defaults; line cells hold nothing valid until written.
module impulse_noise_smoother_top #(
    parameter int MAX_COLS   = 32,
    parameter int PIXEL_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,   // pixel_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]   m_axis_tdata,   // pixel_out
    output logic                              m_axis_tlast,   // run_last
    output logic                              m_axis_tuser,   // frame_end
    input  logic                              cfg_we,
    input  logic [ins_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ins_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ins_pkg::*;

    localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int IDX_W   = $clog2(MAX_COLS);
    localparam int CNT_W   = ($clog2(MAX_COLS + 1) > COLS_W) ? $clog2(MAX_COLS + 1) : COLS_W;

    logic [COLS_W-1:0]     cols_cfg_reg;
    logic [ROWS_W-1:0]     rows_cfg_reg;
    logic [THR_W-1:0]      thr_reg;

    logic [IDX_W-1:0]      pos_c_reg;
    logic [ROWS_W-1:0]     row_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [PIXEL_BITS-1:0] last_left_reg;

    logic                  bnd_busy_reg;
    slot_t                 bnd_slot_reg;
    slot_t                 bnd_top_reg;
    logic [PIXEL_BITS-1:0] bnd_a_reg;
    logic [PIXEL_BITS-1:0] bnd_b_reg;
    logic [PIXEL_BITS-1:0] bnd_pix_reg;

    logic                  m_tvalid_reg;
    logic [PIXEL_BITS-1:0] pix_out_reg;
    logic                  last_out_reg;
    logic                  fend_out_reg;

    logic [CNT_W-1:0]      cols_wide;
    logic [CNT_W-1:0]      cols_eff;
    logic [CNT_W-1:0]      last_idx;
    logic [IDX_W-1:0]      c_eff;
    logic [ROWS_W-1:0]     rows_eff;
    logic [ROWS_W-1:0]     r_eff;
    logic                  last_row;
    logic                  last_col;
    logic                  first_row;
    logic                  c_nz;
    logic                  c_ge2;
    logic                  aligned;
    logic                  rotate;
    logic                  accept;
    logic                  bnd_move;
    logic                  bnd_done;
    logic                  bundle_free;
    logic                  out_free;
    logic [IDX_W-1:0]      head_inc;
    slot_t                 acc_top;
    slot_t                 slot_inc;

    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS-1:0] res_a;
    logic [PIXEL_BITS-1:0] res_b;
    logic [PIXEL_BITS-1:0] res_final;
    logic [PIXEL_BITS-1:0] emit_pix;
    logic                  emit_last;
    logic                  emit_fend;
    nb_valid_t             va;
    nb_valid_t             vb;
    nb_valid_t             vf;

    logic [PIXEL_BITS-1:0] cell_pend   [MAX_COLS];
    logic [PIXEL_BITS-1:0] cell_smooth [MAX_COLS];
    logic [PIXEL_BITS-1:0] wrap_pend;
    logic [PIXEL_BITS-1:0] wrap_smooth;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COLS_RST;
            rows_cfg_reg <= ROWS_RST;
            thr_reg      <= THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLS:   cols_cfg_reg <= cfg_data[COLS_W-1:0];
                CFG_ROWS:   rows_cfg_reg <= cfg_data[ROWS_W-1:0];
                CFG_THRESH: thr_reg      <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // geometry, with saturation of a position past a shrunk frame
    always_comb
    begin
        cols_wide = CNT_W'(cols_cfg_reg);
        if (cols_wide < CNT_W'(2))
            cols_eff = CNT_W'(2);
        else if (cols_wide > CNT_W'(MAX_COLS))
            cols_eff = CNT_W'(MAX_COLS);
        else
            cols_eff = cols_wide;
        last_idx  = cols_eff - CNT_W'(1);
        c_eff     = (CNT_W'(pos_c_reg) > last_idx) ? last_idx[IDX_W-1:0] : pos_c_reg;
        rows_eff  = (rows_cfg_reg < ROWS_W'(2)) ? ROWS_W'(2) : rows_cfg_reg;
        r_eff     = (row_reg > rows_eff - ROWS_W'(1)) ? (rows_eff - ROWS_W'(1)) : row_reg;
        last_row  = (r_eff == rows_eff - ROWS_W'(1));
        last_col  = (CNT_W'(c_eff) == last_idx);
        first_row = (r_eff == '0);
        c_nz      = (c_eff != '0);
        c_ge2     = (CNT_W'(c_eff) >= CNT_W'(2));
        head_inc  = (head_reg == IDX_W'(MAX_COLS - 1)) ? '0 : (head_reg + IDX_W'(1));
    end

    // handshake
    assign pix           = s_axis_tdata[PIXEL_BITS-1:0];
    assign aligned       = (head_reg == c_eff);
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign bnd_move      = bnd_busy_reg && out_free;
    assign bnd_done      = bnd_move && (bnd_slot_reg == bnd_top_reg);
    assign bundle_free   = !bnd_busy_reg || bnd_done;
    assign s_axis_tready = aligned && bundle_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rotate        = accept || !aligned;

    // column ring: cell k holds column head + k
    assign wrap_pend   = accept ? pix : cell_pend[0];
    assign wrap_smooth = (accept && !first_row) ? res_a : cell_smooth[0];

    for (genvar k = 0; k < MAX_COLS; k++)
    begin : g_cell
        if (k == MAX_COLS - 1)
        begin : g_wrap
            ins_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk       (clk),
                .shift_en  (rotate),
                .pend_in   (wrap_pend),
                .smooth_in (wrap_smooth),
                .pend      (cell_pend[k]),
                .smooth    (cell_smooth[k])
            );
        end
        else
        begin : g_link
            ins_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk       (clk),
                .shift_en  (rotate),
                .pend_in   (cell_pend[k+1]),
                .smooth_in (cell_smooth[k+1]),
                .pend      (cell_pend[k]),
                .smooth    (cell_smooth[k])
            );
        end
    end

    // neighbor sets
    always_comb
    begin
        va.up    = (r_eff >= ROWS_W'(2));
        va.down  = 1'b1;
        va.left  = c_nz;
        va.right = !last_col;
        vb.up    = 1'b1;
        vb.down  = 1'b0;
        vb.left  = c_ge2;
        vb.right = 1'b1;
        vf.up    = 1'b1;
        vf.down  = 1'b0;
        vf.left  = 1'b1;
        vf.right = 1'b0;
    end

    ins_smooth #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mid (
        .center    (cell_pend[0]),
        .up        (cell_smooth[0]),
        .down      (pix),
        .left      (left_reg),
        .right     (cell_pend[1 % MAX_COLS]),
        .valid     (va),
        .threshold (thr_reg),
        .result    (res_a)
    );

    ins_smooth #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_left (
        .center    (cell_pend[MAX_COLS-1]),
        .up        (cell_smooth[MAX_COLS-1]),
        .down      (pix),
        .left      (last_left_reg),
        .right     (pix),
        .valid     (vb),
        .threshold (thr_reg),
        .result    (res_b)
    );

    ins_smooth #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_final (
        .center    (bnd_pix_reg),
        .up        (bnd_a_reg),
        .down      (bnd_pix_reg),
        .left      (bnd_b_reg),
        .right     (bnd_pix_reg),
        .valid     (vf),
        .threshold (thr_reg),
        .result    (res_final)
    );

    // results of one item
    always_comb
    begin
        if (!last_row)
            acc_top = SLOT_MID;
        else if (last_col)
            acc_top = SLOT_FINAL;
        else if (c_nz)
            acc_top = SLOT_LEFT;
        else
            acc_top = SLOT_MID;
    end

    always_comb
    begin
        case (bnd_slot_reg)
            SLOT_MID:   slot_inc = SLOT_LEFT;
            SLOT_LEFT:  slot_inc = SLOT_FINAL;
            SLOT_FINAL: slot_inc = SLOT_FINAL;
            default:    slot_inc = SLOT_MID;
        endcase
    end

    always_comb
    begin
        case (bnd_slot_reg)
            SLOT_MID:   emit_pix = bnd_a_reg;
            SLOT_LEFT:  emit_pix = bnd_b_reg;
            SLOT_FINAL: emit_pix = res_final;
            default:    emit_pix = bnd_a_reg;
        endcase
        emit_last = (bnd_slot_reg == bnd_top_reg);
        emit_fend = (bnd_slot_reg == SLOT_FINAL);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_c_reg     <= '0;
            row_reg       <= '0;
            head_reg      <= '0;
            left_reg      <= '0;
            last_left_reg <= '0;
            bnd_busy_reg  <= 1'b0;
            bnd_slot_reg  <= SLOT_MID;
            bnd_top_reg   <= SLOT_MID;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (rotate)
                head_reg <= head_inc;

            if (out_free)
                m_tvalid_reg <= bnd_move;

            if (accept && !first_row)
            begin
                bnd_busy_reg <= 1'b1;
                bnd_slot_reg <= SLOT_MID;
                bnd_top_reg  <= acc_top;
            end
            else if (bnd_move)
            begin
                if (bnd_done)
                    bnd_busy_reg <= 1'b0;
                else
                    bnd_slot_reg <= slot_inc;
            end

            if (accept)
            begin
                if (last_col)
                begin
                    pos_c_reg     <= '0;
                    left_reg      <= '0;
                    last_left_reg <= '0;
                    row_reg       <= last_row ? '0 : (r_eff + ROWS_W'(1));
                end
                else
                begin
                    pos_c_reg <= c_eff + IDX_W'(1);
                    row_reg   <= r_eff;
                    if (!first_row)
                        left_reg <= res_a;
                    if (last_row && c_nz)
                        last_left_reg <= res_b;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bnd_a_reg   <= res_a;
            bnd_b_reg   <= res_b;
            bnd_pix_reg <= pix;
        end
        if (bnd_move)
        begin
            pix_out_reg  <= emit_pix;
            last_out_reg <= emit_last;
            fend_out_reg <= emit_fend;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = TDATA_W'(pix_out_reg);
    assign m_axis_tlast  = last_out_reg;
    assign m_axis_tuser  = fend_out_reg;

`ifndef SYNTH
    a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without run end");

    a_bundle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bnd_busy_reg && !bnd_done |-> !s_axis_tready)
        else $error("item taken while results still queued");

    a_bundle_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !first_row |=> bnd_busy_reg && (bnd_slot_reg == SLOT_MID))
        else $error("results of item not queued");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        bnd_busy_reg |-> bnd_slot_reg <= bnd_top_reg)
        else $error("result slot past end of run");

    a_ring_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> head_reg == $past(head_inc))
        else $error("column ring out of step");
`endif

endmodule
